/* src/iba_pkg.sv */
// shared widths, register indexes and defaults for the inode byte address block
package iba_pkg;

	localparam int INO_W      = 32;
	localparam int ADDR_W     = 63;
	localparam int IPG_W      = 17;
	localparam int REC_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_INODES_PER_GROUP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INODE_RECORD_BYTES = 1'd1;

	localparam logic [IPG_W-1:0] IPG_RESET = 17'd8192;
	localparam logic [REC_W-1:0] REC_RESET = 13'd128;

	localparam int BLOCK_BYTES_DEF  = 4096;
	localparam int GROUP_BLOCKS_DEF = 32768;

	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = INO_W / DIV_BITS;

	localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

endpackage

/* src/iba_if.sv */
// valid/ready channels for inode numbers in and byte addresses out
interface iba_ino_if;
	import iba_pkg::*;

	logic             valid;
	logic             ready;
	logic [INO_W-1:0] inode_number;

	modport source (output valid, output inode_number, input ready);
	modport sink   (input valid, input inode_number, output ready);

endinterface

interface iba_addr_if;
	import iba_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] byte_address;
	logic              group_has_backup;

	modport source (output valid, output byte_address, output group_has_backup, input ready);
	modport sink   (input valid, input byte_address, input group_has_backup, output ready);

endinterface

/* src/inode_byte_address.sv */
// inode number to on-disk byte address, pipelined divider and address arithmetic
//
// in_ch carries one inode number per transaction, out_ch one byte address and the
// backup-group flag per transaction, in the same order. wr_en/wr_index/wr_data set
// inodes_per_group (index 0) and inode_record_bytes (index 1); the user must write
// them only while idle, as the block itself does not enforce it.
// Throughput is one transaction per cycle while out_ch does not stall. The divider
// takes DIV_BITS = 4 quotient bits per stage over 8 stages, then one stage multiplies
// (group span, slot offset, backup test), one adds the base and span, and the output
// register adds the slot offset and saturates at 2^63-1.
// Reset empties every stage and loads inodes_per_group 8192 and
// inode_record_bytes 128; an inodes_per_group of 0 divides by 1.
// When out_ch stalls, the output register holds its transaction and each stage
// holds only while the one after it is full and not moving, so empty stages still
// fill and in_ch keeps accepting until the whole pipeline is full.
module inode_byte_address #(
	parameter int BLOCK_BYTES  = iba_pkg::BLOCK_BYTES_DEF,
	parameter int GROUP_BLOCKS = iba_pkg::GROUP_BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [iba_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [iba_pkg::CFG_DATA_W-1:0] wr_data,
	iba_ino_if.sink                        in_ch,
	iba_addr_if.source                     out_ch
);
	import iba_pkg::*;

	localparam logic [63:0] GROUP_BYTES = 64'(BLOCK_BYTES) * 64'(GROUP_BLOCKS);
	localparam int          GB_W        = $clog2(GROUP_BYTES + 64'd1);
	localparam int          PROD_W      = INO_W + GB_W;
	localparam int          SLOTP_W     = IPG_W + REC_W;
	localparam logic [63:0] BASE_PLAIN  = 64'(BLOCK_BYTES) * 64'd2;
	localparam logic [63:0] BASE_BACKUP = 64'(BLOCK_BYTES) * 64'd4;
	localparam int          POW_STEPS   = 21;
	localparam int          ST_MUL      = DIV_STAGES;
	localparam int          ST_SUM      = DIV_STAGES + 1;
	localparam int          ST_OUT      = DIV_STAGES + 2;
	localparam int          NS          = DIV_STAGES + 3;

	function automatic logic [IPG_W+INO_W-1:0] div_step(
		input logic [IPG_W-1:0] rem,
		input logic [INO_W-1:0] qd,
		input logic [IPG_W-1:0] d
	);
		logic [IPG_W:0]   t;
		logic [IPG_W-1:0] r;
		logic [INO_W-1:0] q;
		r = rem;
		q = qd;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r, q[INO_W-1]};
			q = {q[INO_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				q[0] = 1'b1;
			end
			r = t[IPG_W-1:0];
		end
		return {r, q};
	endfunction

	// group 0, or an exact power of 3, 5 or 7 (group 1 is the zeroth power)
	function automatic logic is_backup(input logic [INO_W-1:0] g);
		logic        hit;
		logic [63:0] p3;
		logic [63:0] p5;
		logic [63:0] p7;
		hit = (g == '0);
		p3  = 64'd1;
		p5  = 64'd1;
		p7  = 64'd1;
		for (int k = 0; k < POW_STEPS; k++) begin
			hit = hit | (64'(g) == p3) | (64'(g) == p5) | (64'(g) == p7);
			p3  = p3 * 64'd3;
			p5  = p5 * 64'd5;
			p7  = p7 * 64'd7;
		end
		return hit;
	endfunction

	logic [IPG_W-1:0] ipg_q;
	logic [REC_W-1:0] rec_q;
	logic [IPG_W-1:0] divisor;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] take;

	logic [IPG_W-1:0] div_rem_s [DIV_STAGES];
	logic [INO_W-1:0] div_quo_s [DIV_STAGES];

	logic [PROD_W-1:0]  span_s9;
	logic [SLOTP_W-1:0] slotp_s9;
	logic               backup_s9;

	logic [63:0]        sum_s10;
	logic [SLOTP_W-1:0] slotp_s10;
	logic               backup_s10;

	logic [ADDR_W-1:0] addr_s11;
	logic              backup_s11;

	logic [ADDR_W-1:0] span_sat;
	logic [63:0]       base_sel;
	logic [64:0]       total;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipg_q <= IPG_RESET;
			rec_q <= REC_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INODES_PER_GROUP:   ipg_q <= wr_data[IPG_W-1:0];
				REG_INODE_RECORD_BYTES: rec_q <= wr_data[REC_W-1:0];
				default: ;
			endcase
		end
	end

	assign divisor = (ipg_q == '0) ? IPG_W'(1) : ipg_q;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		take[NS-1] = !vld_s[NS-1] || out_ch.ready;
		for (int i = NS - 2; i >= 0; i--) begin
			take[i] = !vld_s[i] || take[i+1];
		end
	end

	assign in_ch.ready = take[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (take[0]) begin
				vld_s[0] <= in_ch.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (take[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// restoring divider, DIV_BITS quotient bits per stage
	always_ff @(posedge clk) begin
		if (take[0]) begin
			{div_rem_s[0], div_quo_s[0]} <= div_step('0, in_ch.inode_number, divisor);
		end
		for (int j = 1; j < DIV_STAGES; j++) begin
			if (take[j]) begin
				{div_rem_s[j], div_quo_s[j]} <= div_step(div_rem_s[j-1], div_quo_s[j-1], divisor);
			end
		end
	end

	// products and backup test
	always_ff @(posedge clk) begin
		if (take[ST_MUL]) begin
			span_s9   <= PROD_W'(div_quo_s[DIV_STAGES-1]) * PROD_W'(GROUP_BYTES[GB_W-1:0]);
			slotp_s9  <= SLOTP_W'(div_rem_s[DIV_STAGES-1]) * SLOTP_W'(rec_q);
			backup_s9 <= is_backup(div_quo_s[DIV_STAGES-1]);
		end
	end

	always_comb begin
		span_sat = (65'(span_s9) > 65'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(span_s9);
		base_sel = backup_s9 ? BASE_BACKUP : BASE_PLAIN;
		total    = 65'(sum_s10) + 65'(slotp_s10);
	end

	always_ff @(posedge clk) begin
		if (take[ST_SUM]) begin
			sum_s10    <= base_sel + 64'(span_sat);
			slotp_s10  <= slotp_s9;
			backup_s10 <= backup_s9;
		end
		if (take[ST_OUT]) begin
			addr_s11   <= (total > 65'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(total);
			backup_s11 <= backup_s10;
		end
	end

	assign out_ch.valid            = vld_s[ST_OUT];
	assign out_ch.byte_address     = addr_s11;
	assign out_ch.group_has_backup = backup_s11;

endmodule
